### rtl/core/pft_pkg.sv
// Shared types and constants of the packet filter rule table.
// No dependencies; the other files of the block, but for pft_ram, refer to it by scoped names.
`timescale 1ns / 1ps

package pft_pkg;

  typedef enum logic [1:0] {
    REQ_CHECK  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } pft_req_kind_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef struct packed {
    pft_req_kind_t req_type;
    logic [7:0]    protocol;
    logic [31:0]   src_addr;
    logic [31:0]   dst_addr;
    logic [15:0]   src_port;
    logic [15:0]   dst_port;
    logic          rule_direction;
    logic [31:0]   rule_addr;
    logic [15:0]   rule_port;
    logic [3:0]    entry_index;
  } pft_req_t;

  typedef struct packed {
    logic        verdict;
    logic [3:0]  matched_index;
    logic [1:0]  status;
    logic        entry_valid;
    logic [7:0]  entry_protocol;
    logic        entry_direction;
    logic [31:0] entry_addr;
    logic [15:0] entry_port;
    logic [31:0] entry_drops;
  } pft_rsp_t;

  // One stored rule, as held in the rule memory.
  typedef struct packed {
    logic [7:0]  protocol;
    logic        direction;
    logic [31:0] addr;
    logic [15:0] port;
  } pft_rule_t;

  typedef struct packed {
    logic       start;
    logic       scan;
    logic       rd_entry;
    logic       set_drop;
    logic       cnt_update;
    logic       add_write;
    logic       remove;
    logic       set_status;
    logic [1:0] status_code;
    logic       load_out;
  } pft_cmd_t;

  typedef struct packed {
    pft_req_kind_t req_type;
    logic          foreign;
    logic          oob;
    logic          hit;
    logic          last;
    logic          free_found;
  } pft_stat_t;

endpackage

### rtl/core/packet_filter_rule_table.sv
// Top level of the packet filter rule table; joins the sequencer and the datapath.
// Depends on pft_pkg, pft_ctrl, pft_datapath.
`timescale 1ns / 1ps

// One request is in flight at a time. A packet check, an add or a remove walks the
// rule memory one entry per cycle in table order and ends early at the first
// matching entry; a check that matches then writes back its drop counter. A read,
// and a check of a protocol other than UDP or TCP, skips the walk. The result waits
// in an output register; the next request is taken once that register has been
// loaded.

module packet_filter_rule_table #(
  parameter int RULES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  pft_pkg::pft_req_t req,
  input  logic              req_valid,
  output logic              req_stall,
  output pft_pkg::pft_rsp_t rsp,
  output logic              rsp_valid,
  input  logic              rsp_stall
);

  pft_pkg::pft_cmd_t  cmd;
  pft_pkg::pft_stat_t stat;

  pft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pft_datapath #(
    .RULES (RULES)
  ) u_datapath (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule

### rtl/core/pft_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module pft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/pft_ctrl.sv
// Sequencer of the packet filter rule table: accepts a request, steps the scan and
// finishes the result. Depends on pft_pkg.
`timescale 1ns / 1ps

module pft_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  input  pft_pkg::pft_stat_t stat,
  output pft_pkg::pft_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (stat.req_type)
          pft_pkg::REQ_CHECK: begin
            if (stat.foreign) begin
              state_next = S_FINISH;
            end else begin
              cmd.scan   = 1'b1;
              state_next = S_SCAN;
            end
          end
          pft_pkg::REQ_ADD, pft_pkg::REQ_REMOVE: begin
            cmd.scan   = 1'b1;
            state_next = S_SCAN;
          end
          pft_pkg::REQ_READ: begin
            cmd.rd_entry = !stat.oob;
            state_next   = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        if (stat.hit) begin
          state_next = S_FINISH;
          unique case (stat.req_type)
            pft_pkg::REQ_CHECK: begin
              cmd.set_drop = 1'b1;
              state_next   = S_UPDATE;
            end
            pft_pkg::REQ_ADD: begin
              cmd.set_status  = 1'b1;
              cmd.status_code = pft_pkg::ST_DUPLICATE;
            end
            pft_pkg::REQ_REMOVE: begin
              cmd.remove = 1'b1;
            end
            pft_pkg::REQ_READ: begin
            end
          endcase
        end else if (stat.last) begin
          state_next = S_FINISH;
          unique case (stat.req_type)
            pft_pkg::REQ_ADD: begin
              if (stat.free_found) begin
                cmd.add_write = 1'b1;
              end else begin
                cmd.set_status  = 1'b1;
                cmd.status_code = pft_pkg::ST_FULL;
              end
            end
            pft_pkg::REQ_REMOVE: begin
              cmd.set_status  = 1'b1;
              cmd.status_code = pft_pkg::ST_NOT_FOUND;
            end
            pft_pkg::REQ_CHECK, pft_pkg::REQ_READ: begin
            end
          endcase
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.cnt_update = 1'b1;
        state_next     = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

### rtl/core/pft_datapath.sv
// Datapath of the packet filter rule table: request register, rule and counter
// memories, valid bits, match logic and result register. Depends on pft_pkg, pft_ram.
`timescale 1ns / 1ps

module pft_datapath #(
  parameter int RULES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pft_pkg::pft_req_t  req,
  input  pft_pkg::pft_cmd_t  cmd,
  output pft_pkg::pft_stat_t stat,
  output pft_pkg::pft_rsp_t  rsp
);

  localparam int IW = (RULES > 1) ? $clog2(RULES) : 1;

  pft_pkg::pft_req_t  cur;
  pft_pkg::pft_rule_t rule_wdata, rule_rdata;
  pft_pkg::pft_rsp_t  rsp_next;

  logic [RULES-1:0] valid;
  logic [IW:0]      cnt;
  logic             chk_en;
  logic [IW-1:0]    chk_idx;
  logic             free_found, free_found_next;
  logic [IW-1:0]    free_idx, free_idx_next;
  logic [IW-1:0]    hit_idx;
  logic [31:0]      drop_inc;
  logic             res_verdict;
  logic [3:0]       res_match;
  logic [1:0]       res_status;

  logic             more, issue, rd_en;
  logic [IW-1:0]    raddr;
  logic [IW+3:0]    idx_wide;
  logic [IW+3:0]    chk_wide;
  logic [IW-1:0]    idx_addr;
  logic             oob;
  logic             cnt_we;
  logic [IW-1:0]    cnt_waddr;
  logic [31:0]      cnt_wdata, cnt_rdata;

  logic             entry_v, same, port_any, addr_any, addr_eq, port_eq, pkt_hit;
  logic [31:0]      paddr;
  logic [15:0]      pport;

  assign more     = (cnt < (IW + 1)'(RULES));
  assign issue    = cmd.scan && more;
  assign rd_en    = issue || cmd.rd_entry;
  assign idx_wide = (IW + 4)'(cur.entry_index);
  assign idx_addr = idx_wide[IW-1:0];
  assign oob      = (idx_wide >= (IW + 4)'(RULES));
  assign raddr    = cmd.rd_entry ? idx_addr : cnt[IW-1:0];
  assign chk_wide = (IW + 4)'(chk_idx);

  assign rule_wdata.protocol  = cur.protocol;
  assign rule_wdata.direction = cur.rule_direction;
  assign rule_wdata.addr      = cur.rule_addr;
  assign rule_wdata.port      = cur.rule_port;

  assign cnt_we    = cmd.add_write || cmd.cnt_update;
  assign cnt_waddr = cmd.cnt_update ? hit_idx : free_idx_next;
  assign cnt_wdata = cmd.cnt_update ? drop_inc : 32'd0;

  pft_ram #(
    .WIDTH ($bits(pft_pkg::pft_rule_t)),
    .DEPTH (RULES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (cmd.add_write),
    .waddr (free_idx_next),
    .wdata (rule_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rule_rdata)
  );

  pft_ram #(
    .WIDTH (32),
    .DEPTH (RULES)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (cnt_rdata)
  );

  // Compare the entry whose memory word arrived this cycle against the request.
  always_comb begin
    entry_v  = valid[chk_idx];
    same     = entry_v && (rule_rdata.protocol == cur.protocol) &&
               (rule_rdata.direction == cur.rule_direction) &&
               (rule_rdata.addr == cur.rule_addr) && (rule_rdata.port == cur.rule_port);
    paddr    = rule_rdata.direction ? cur.dst_addr : cur.src_addr;
    pport    = rule_rdata.direction ? cur.dst_port : cur.src_port;
    port_any = (rule_rdata.port == 16'd0);
    addr_any = (rule_rdata.addr == 32'd0);
    addr_eq  = (rule_rdata.addr == paddr);
    port_eq  = (rule_rdata.port == pport);
    priority if (port_any) begin
      pkt_hit = addr_eq;
    end else if (addr_any) begin
      pkt_hit = port_eq;
    end else begin
      pkt_hit = addr_eq && port_eq;
    end
    pkt_hit = pkt_hit && entry_v && (rule_rdata.protocol == cur.protocol);
  end

  always_comb begin
    if (!free_found && chk_en && !entry_v) begin
      free_found_next = 1'b1;
      free_idx_next   = chk_idx;
    end else begin
      free_found_next = free_found;
      free_idx_next   = free_idx;
    end
  end

  assign stat.req_type   = cur.req_type;
  assign stat.foreign    = (cur.protocol != pft_pkg::PROTO_UDP) &&
                           (cur.protocol != pft_pkg::PROTO_TCP);
  assign stat.oob        = oob;
  assign stat.hit        = chk_en && ((cur.req_type == pft_pkg::REQ_CHECK) ? pkt_hit : same);
  assign stat.last       = chk_en && (chk_idx == IW'(RULES - 1));
  assign stat.free_found = free_found_next;

  always_comb begin
    rsp_next               = '0;
    rsp_next.verdict       = res_verdict;
    rsp_next.matched_index = res_match;
    rsp_next.status        = res_status;
    if ((cur.req_type == pft_pkg::REQ_READ) && !oob) begin
      rsp_next.entry_valid     = valid[idx_addr];
      rsp_next.entry_protocol  = rule_rdata.protocol;
      rsp_next.entry_direction = rule_rdata.direction;
      rsp_next.entry_addr      = rule_rdata.addr;
      rsp_next.entry_port      = rule_rdata.port;
      // A free entry always shows a drop count of zero, whatever its counter holds.
      rsp_next.entry_drops     = valid[idx_addr] ? cnt_rdata : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      chk_en <= 1'b0;
    end else begin
      chk_en <= issue;
      if (cmd.add_write) begin
        valid[free_idx_next] <= 1'b1;
      end
      if (cmd.remove) begin
        valid[chk_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur         <= req;
      cnt         <= '0;
      free_found  <= 1'b0;
      res_verdict <= 1'b0;
      res_match   <= 4'd0;
      res_status  <= pft_pkg::ST_OK;
    end else begin
      if (issue) begin
        cnt <= cnt + (IW + 1)'(1);
      end
      free_found <= free_found_next;
      if (cmd.set_drop) begin
        res_verdict <= 1'b1;
        res_match   <= chk_wide[3:0];
      end
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
    end
    if (issue) begin
      chk_idx <= cnt[IW-1:0];
    end
    free_idx <= free_idx_next;
    if (cmd.set_drop) begin
      hit_idx  <= chk_idx;
      drop_inc <= (cnt_rdata == 32'hFFFF_FFFF) ? cnt_rdata : cnt_rdata + 32'd1;
    end
    if (cmd.load_out) begin
      rsp <= rsp_next;
    end
  end

endmodule

### rtl/core/pft_checker.sv
// Port-level checks of the packet filter rule table, bound to the top level.
// Depends on pft_pkg and packet_filter_rule_table.
`timescale 1ns / 1ps

module pft_checker (
  input logic              clk,
  input logic              rst,
  input pft_pkg::pft_req_t req,
  input logic              req_valid,
  input logic              req_stall,
  input pft_pkg::pft_rsp_t rsp,
  input logic              rsp_valid,
  input logic              rsp_stall
);

  // A stalled result stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Only one request is worked on at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while another is in flight");

  // A result appears only at the end of a request's work.
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("result without a request in flight");

  // A drop verdict comes with status OK and no valid entry.
  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.verdict |-> rsp.status == pft_pkg::ST_OK && !rsp.entry_valid)
    else $error("drop verdict mixed with other result fields");

  // A free entry never shows a drop count.
  a_free_no_drops: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.entry_valid |-> rsp.entry_drops == 32'd0)
    else $error("drop count on an entry not in use");

endmodule

bind packet_filter_rule_table pft_checker u_pft_checker (
  .clk       (clk),
  .rst       (rst),
  .req       (req),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall)
);
